// ===== hw/rtl/ocp_pkg.sv =====
// Shared types, codes and field layout for the order crossover permutation core.
// Used by order_crossover_permutation_core; has no dependencies of its own.
package ocp_pkg;

    localparam int MAX_CLIENTS_DEF = 1024;

    localparam int ACT_W    = 2;
    localparam int POS_W    = 10;
    localparam int GENE_W   = 11;
    localparam int STATUS_W = 2;
    localparam int CC_W     = 11;

    localparam logic [CC_W-1:0] CC_RESET = 11'd2;

    // Input tdata layout, lowest field first, padded to whole bytes.
    localparam int POS_LSB     = 0;
    localparam int G1_LSB      = POS_LSB + POS_W;
    localparam int G2_LSB      = G1_LSB + GENE_W;
    localparam int CS_LSB      = G2_LSB + GENE_W;
    localparam int CE_LSB      = CS_LSB + POS_W;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 16;

    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CUT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_PERM = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SEG,
        S_FILL,
        S_DRAIN,
        S_RESP
    } t_state;

endpackage

// ===== hw/rtl/ocp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; instanced for every chromosome store and the inserted marks.
module ocp_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/order_crossover_permutation_core.sv =====
// Order crossover (OX) core: parent and offspring chromosome stores with a crossover sequencer.
// Depends on ocp_pkg and ocp_ram.
//
// Usage: items arrive on the s_axis channel, tuser carrying the action (load, compute, read)
// and tdata the position, both parent genes and the two cut points. Every item gives exactly
// one result on m_axis: tuser carries the status and tdata the offspring gene, which is zero
// except for a successful read. The client count is written over the cfg channel, which is
// always ready and must only be used while no transaction is outstanding.
// Load and read items write or read the stores in the accepting cycle; the result then
// passes into the output register once the output is free.
// A compute item for n clients makes three passes: a pass that clears the inserted marks for
// clients 1 to n, a pass that copies the first parent's segment, and a fill pass of n
// positions over the second parent. All three passes are limited by the single write port
// of the marks memory and one store access per position per cycle.
// The output register parts the two sides: a new item is accepted while an earlier result
// still waits, but a second result stalls the core until the receiver takes the first.
// Reset is synchronous; it empties the output, returns to idle and sets the client count to
// two. Store contents are undefined after reset until loaded; marks are cleared per compute.
module order_crossover_permutation_core #(
    parameter int MAX_CLIENTS = ocp_pkg::MAX_CLIENTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input item: tdata = position, first_parent_gene, second_parent_gene, cut_start, cut_end.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ocp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser = action.
    input  logic [ocp_pkg::ACT_W-1:0]     s_axis_tuser,
    // Result item: tdata = offspring_gene.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ocp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser = status.
    output logic [ocp_pkg::STATUS_W-1:0]  m_axis_tuser,
    // Client count register write.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ocp_pkg::CC_W-1:0]      i_cfg_data
);

    localparam int AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int NW = $clog2(MAX_CLIENTS + 1);
    localparam int CW = $clog2(2 * MAX_CLIENTS + 1);
    localparam int XW = (NW > ocp_pkg::GENE_W) ? NW : ocp_pkg::GENE_W;
    localparam int GW = ocp_pkg::GENE_W;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p,
                                              input logic [NW-1:0] n);
        logic [XW-1:0] nxt;
        nxt = XW'(p) + XW'(1);
        return (nxt == XW'(n)) ? '0 : AW'(nxt);
    endfunction

    // Control registers.
    ocp_pkg::t_state                r_state, n_state;
    logic [ocp_pkg::CC_W-1:0]       r_client_count, n_client_count;
    logic                           r_s1_v, n_s1_v;
    logic                           r_f1_v, n_f1_v;
    logic                           r_f2_v, n_f2_v;
    logic                           r_out_valid, n_out_valid;

    // Payload and sequencing registers.
    logic [AW-1:0]                  r_start, n_start;
    logic [AW-1:0]                  r_end, n_end;
    logic [AW-1:0]                  r_ptr, n_ptr;
    logic [AW-1:0]                  r_wp, n_wp;
    logic [AW-1:0]                  r_s1_addr, n_s1_addr;
    logic [NW-1:0]                  r_clr, n_clr;
    logic [NW-1:0]                  r_fill, n_fill;
    logic [CW-1:0]                  r_count, n_count;
    logic [GW-1:0]                  r_g2, n_g2;
    logic                           r_f2_inr, n_f2_inr;
    logic [ocp_pkg::STATUS_W-1:0]   r_status, n_status;
    logic                           r_rd_ok, n_rd_ok;
    logic [ocp_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic [GW-1:0]                  r_out_gene, n_out_gene;

    // Memory ports.
    logic            p1_we, p2_we, p1_re, p2_re;
    logic [AW-1:0]   ld_addr, p1_raddr, p2_raddr;
    logic [GW-1:0]   ld_g1, ld_g2, p1_rdata, p2_rdata;
    logic            off_we, off_re;
    logic [AW-1:0]   off_waddr, off_raddr;
    logic [GW-1:0]   off_wdata, off_rdata;
    logic            mk_we, mk_re;
    logic [NW-1:0]   mk_waddr, mk_raddr;
    logic            mk_wdata, mk_rdata;

    // Decoded input and derived values.
    logic                          accept;
    logic                          out_free;
    logic [ocp_pkg::ACT_W-1:0]     in_act;
    logic [ocp_pkg::POS_W-1:0]     in_pos, in_cs, in_ce;
    logic [XW-1:0]                 cc_x, n_x;
    logic [NW-1:0]                 eff_n;
    logic                          pos_ok, cut_bad;
    logic                          s1_inr, f1_inr;

    assign in_act = s_axis_tuser;
    assign in_pos = s_axis_tdata[ocp_pkg::POS_LSB +: ocp_pkg::POS_W];
    assign ld_g1  = s_axis_tdata[ocp_pkg::G1_LSB +: GW];
    assign ld_g2  = s_axis_tdata[ocp_pkg::G2_LSB +: GW];
    assign in_cs  = s_axis_tdata[ocp_pkg::CS_LSB +: ocp_pkg::POS_W];
    assign in_ce  = s_axis_tdata[ocp_pkg::CE_LSB +: ocp_pkg::POS_W];

    // The effective client count is the register clamped to 2 .. MAX_CLIENTS.
    assign cc_x  = XW'(r_client_count);
    assign n_x   = (cc_x < XW'(2)) ? XW'(2)
                 : ((cc_x > XW'(MAX_CLIENTS)) ? XW'(MAX_CLIENTS) : cc_x);
    assign eff_n = NW'(n_x);

    assign pos_ok  = XW'(in_pos) < n_x;
    assign cut_bad = (in_cs == in_ce) || (XW'(in_cs) >= n_x) || (XW'(in_ce) >= n_x);
    assign s1_inr  = (p1_rdata != '0) && (XW'(p1_rdata) <= n_x);
    assign f1_inr  = (p2_rdata != '0) && (XW'(p2_rdata) <= n_x);

    assign s_axis_tready = (r_state == ocp_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign ld_addr  = AW'(in_pos);
    assign off_raddr = AW'(in_pos);
    assign p1_raddr = r_ptr;
    assign p2_raddr = r_ptr;

    always_comb begin
        n_state        = r_state;
        n_client_count = r_client_count;
        n_s1_v         = 1'b0;
        n_f1_v         = 1'b0;
        n_f2_v         = 1'b0;
        n_out_valid    = r_out_valid && !m_axis_tready;
        n_start        = r_start;
        n_end          = r_end;
        n_ptr          = r_ptr;
        n_wp           = r_wp;
        n_s1_addr      = r_s1_addr;
        n_clr          = r_clr;
        n_fill         = r_fill;
        n_count        = r_count;
        n_g2           = r_g2;
        n_f2_inr       = r_f2_inr;
        n_status       = r_status;
        n_rd_ok        = r_rd_ok;
        n_out_status   = r_out_status;
        n_out_gene     = r_out_gene;
        p1_we          = 1'b0;
        p2_we          = 1'b0;
        p1_re          = 1'b0;
        p2_re          = 1'b0;
        off_we         = 1'b0;
        off_re         = 1'b0;
        off_waddr      = r_s1_addr;
        off_wdata      = p1_rdata;
        mk_we          = 1'b0;
        mk_waddr       = r_clr;
        mk_wdata       = 1'b0;
        mk_re          = 1'b0;
        mk_raddr       = '0;

        if (i_cfg_valid) begin
            n_client_count = i_cfg_data;
        end

        unique case (r_state)
            ocp_pkg::S_IDLE: begin
                if (accept) begin
                    n_rd_ok = 1'b0;
                    n_state = ocp_pkg::S_RESP;
                    unique case (in_act)
                        ocp_pkg::ACT_LOAD: begin
                            p1_we    = pos_ok;
                            p2_we    = pos_ok;
                            n_status = pos_ok ? ocp_pkg::ST_OK : ocp_pkg::ST_BAD_POS;
                        end
                        ocp_pkg::ACT_COMPUTE: begin
                            if (cut_bad) begin
                                n_status = ocp_pkg::ST_BAD_CUT;
                            end else begin
                                n_start = AW'(in_cs);
                                n_end   = AW'(in_ce);
                                n_clr   = NW'(1);
                                n_count = '0;
                                n_state = ocp_pkg::S_CLEAR;
                            end
                        end
                        ocp_pkg::ACT_READ: begin
                            off_re   = pos_ok;
                            n_rd_ok  = pos_ok;
                            n_status = pos_ok ? ocp_pkg::ST_OK : ocp_pkg::ST_BAD_POS;
                        end
                        default: begin
                            n_status = ocp_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ocp_pkg::S_CLEAR: begin
                mk_we = 1'b1;
                if (r_clr == eff_n) begin
                    n_ptr   = r_start;
                    n_state = ocp_pkg::S_SEG;
                end else begin
                    n_clr = r_clr + NW'(1);
                end
            end
            ocp_pkg::S_SEG: begin
                p1_re     = 1'b1;
                n_s1_v    = 1'b1;
                n_s1_addr = r_ptr;
                n_count   = r_count + CW'(1);
                if (r_ptr == r_end) begin
                    n_ptr   = wrap_inc(r_end, eff_n);
                    n_wp    = wrap_inc(r_end, eff_n);
                    n_fill  = '0;
                    n_state = ocp_pkg::S_FILL;
                end else begin
                    n_ptr = wrap_inc(r_ptr, eff_n);
                end
            end
            ocp_pkg::S_FILL: begin
                p2_re  = 1'b1;
                n_f1_v = 1'b1;
                n_ptr  = wrap_inc(r_ptr, eff_n);
                n_fill = r_fill + NW'(1);
                if ((r_fill + NW'(1)) == eff_n) begin
                    n_state = ocp_pkg::S_DRAIN;
                end
            end
            ocp_pkg::S_DRAIN: begin
                if (!r_f1_v && !r_f2_v) begin
                    n_status = (r_count == CW'(eff_n)) ? ocp_pkg::ST_OK
                                                        : ocp_pkg::ST_NOT_PERM;
                    n_state  = ocp_pkg::S_RESP;
                end
            end
            ocp_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_gene   = r_rd_ok ? off_rdata : '0;
                    n_state      = ocp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ocp_pkg::S_IDLE;
            end
        endcase

        // Segment copy, second stage: the first parent's gene goes to the offspring and,
        // when it names a client, sets that client's mark.
        if (r_s1_v) begin
            off_we    = 1'b1;
            off_waddr = r_s1_addr;
            off_wdata = p1_rdata;
            if (s1_inr) begin
                mk_we    = 1'b1;
                mk_waddr = NW'(p1_rdata);
                mk_wdata = 1'b1;
            end
        end

        // Fill, second stage: look up the mark of the second parent's gene.
        if (r_f1_v) begin
            mk_re    = 1'b1;
            mk_raddr = f1_inr ? NW'(p2_rdata) : '0;
            n_f2_v   = 1'b1;
            n_g2     = p2_rdata;
            n_f2_inr = f1_inr;
        end

        // Fill, third stage: an unmarked client is placed while room remains; every
        // such client is counted, so a surplus shows up in the final count.
        if (r_f2_v && r_f2_inr && !mk_rdata) begin
            if (r_count < CW'(eff_n)) begin
                off_we    = 1'b1;
                off_waddr = r_wp;
                off_wdata = r_g2;
                n_wp      = wrap_inc(r_wp, eff_n);
            end
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ocp_pkg::S_IDLE;
            r_client_count <= ocp_pkg::CC_RESET;
            r_s1_v         <= 1'b0;
            r_f1_v         <= 1'b0;
            r_f2_v         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_client_count <= n_client_count;
            r_s1_v         <= n_s1_v;
            r_f1_v         <= n_f1_v;
            r_f2_v         <= n_f2_v;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start      <= n_start;
        r_end        <= n_end;
        r_ptr        <= n_ptr;
        r_wp         <= n_wp;
        r_s1_addr    <= n_s1_addr;
        r_clr        <= n_clr;
        r_fill       <= n_fill;
        r_count      <= n_count;
        r_g2         <= n_g2;
        r_f2_inr     <= n_f2_inr;
        r_status     <= n_status;
        r_rd_ok      <= n_rd_ok;
        r_out_status <= n_out_status;
        r_out_gene   <= n_out_gene;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = ocp_pkg::M_TDATA_W'(r_out_gene);

    ocp_ram #(.WIDTH(GW), .DEPTH(MAX_CLIENTS)) u_first_parent (
        .i_clk   (i_clk),
        .i_we    (p1_we),
        .i_waddr (ld_addr),
        .i_wdata (ld_g1),
        .i_re    (p1_re),
        .i_raddr (p1_raddr),
        .o_rdata (p1_rdata)
    );

    ocp_ram #(.WIDTH(GW), .DEPTH(MAX_CLIENTS)) u_second_parent (
        .i_clk   (i_clk),
        .i_we    (p2_we),
        .i_waddr (ld_addr),
        .i_wdata (ld_g2),
        .i_re    (p2_re),
        .i_raddr (p2_raddr),
        .o_rdata (p2_rdata)
    );

    ocp_ram #(.WIDTH(GW), .DEPTH(MAX_CLIENTS)) u_offspring (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_waddr (off_waddr),
        .i_wdata (off_wdata),
        .i_re    (off_re),
        .i_raddr (off_raddr),
        .o_rdata (off_rdata)
    );

    ocp_ram #(.WIDTH(1), .DEPTH(MAX_CLIENTS + 1)) u_marks (
        .i_clk   (i_clk),
        .i_we    (mk_we),
        .i_waddr (mk_waddr),
        .i_wdata (mk_wdata),
        .i_re    (mk_re),
        .i_raddr (mk_raddr),
        .o_rdata (mk_rdata)
    );

`ifndef ASSERT_OFF
    // The marks are only read during the fill, when nothing may write them.
    a_marks_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mk_we |-> !r_f1_v)
        else $error("marks written while a fill lookup is in flight");

    // No item is taken while a compute pipeline still holds work.
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!r_s1_v && !r_f1_v && !r_f2_v))
        else $error("input accepted with crossover pipeline busy");

    // A pending result moves to the output as soon as the output register frees.
    a_resp_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ocp_pkg::S_RESP && out_free) |=>
            (r_state == ocp_pkg::S_IDLE && m_axis_tvalid))
        else $error("result not passed to output register");
`endif

endmodule
